// ===== rtl/velocity_vector_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// velocity vector limiter assertion macros
// shared property forms for the limiter and its divider
// ----------------------------------------------------------------------------
`ifndef VELOCITY_VECTOR_LIMITER_DEFINES_SVH
`define VELOCITY_VECTOR_LIMITER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define VVL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define VVL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vvl_pkg.sv =====
// ----------------------------------------------------------------------------
// vvl_pkg
// types, constants and helpers of the velocity vector limiter
// ----------------------------------------------------------------------------
package vvl_pkg;

  // field widths
  localparam int VEL_W      = 16;
  localparam int LIMIT_W    = 16;
  localparam int AXIS_W     = 4;
  localparam int RATIO_W    = 32;
  localparam int STEP_W     = 6;

  // configuration port
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  // register indexes (paddr[5:3])
  localparam logic [2:0] REG_JOINT_COUNT  = 3'd0;
  localparam logic [2:0] REG_BASE_ACTIVE  = 3'd1;
  localparam logic [2:0] REG_LIMITS_LOW   = 3'd2;
  localparam logic [2:0] REG_LIMITS_HIGH  = 3'd3;
  localparam logic [2:0] REG_BASE_LIMITS  = 3'd4;

  // register reset values
  localparam logic [3:0]  JOINT_COUNT_RST = 4'd7;
  localparam logic [63:0] JOINT_LIM_RST   = 64'h1000_1000_1000_1000;
  localparam logic [31:0] BASE_LIM_RST    = 32'h1000_1000;

  // 1.0 in unsigned Q16.16
  localparam logic [RATIO_W-1:0] ONE_Q16 = 32'h0001_0000;

  // divider step counts
  localparam logic [STEP_W-1:0] RATIO_STEPS = 6'd32;
  localparam logic [STEP_W-1:0] SCALE_STEPS = 6'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO,
    ST_EMIT,
    ST_SCALE,
    ST_OUT
  } vvl_state_e;

  // divider request
  typedef struct packed {
    logic               start;
    logic [RATIO_W-1:0] rem_init;
    logic [RATIO_W-1:0] dividend;
    logic [RATIO_W-1:0] divisor;
    logic [STEP_W-1:0]  steps;
  } vvl_div_req_t;

  // divider response
  typedef struct packed {
    logic               busy;
    logic [RATIO_W-1:0] quotient;
  } vvl_div_rsp_t;

  // magnitude of a signed q4.12 value, -32768 gives 32768
  function automatic logic [VEL_W-1:0] mag16(input logic [VEL_W-1:0] v);
    logic [VEL_W-1:0] r;
    r = v[VEL_W-1] ? ((~v) + 16'd1) : v;
    return r;
  endfunction

endpackage

// ===== rtl/vvl_in_if.sv =====
// ----------------------------------------------------------------------------
// vvl_in_if
// input channel: one commanded axis velocity per transfer
// ----------------------------------------------------------------------------
interface vvl_in_if import vvl_pkg::*;;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] velocity;

  modport source (output valid, output velocity, input ready);
  modport sink   (input valid, input velocity, output ready);

endinterface

// ===== rtl/vvl_out_if.sv =====
// ----------------------------------------------------------------------------
// vvl_out_if
// output channel: one scaled axis velocity per transfer
// ----------------------------------------------------------------------------
interface vvl_out_if import vvl_pkg::*;;

  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       axis;
  logic signed [VEL_W-1:0] scaled_velocity;
  logic                    was_scaled;
  logic                    last;

  modport source (output valid, output axis, output scaled_velocity,
                  output was_scaled, output last, input ready);
  modport sink   (input valid, input axis, input scaled_velocity,
                  input was_scaled, input last, output ready);

endinterface

// ===== rtl/vvl_div.sv =====
// ----------------------------------------------------------------------------
// vvl_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "velocity_vector_limiter_defines.svh"

module vvl_div import vvl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vvl_div_req_t req_i,
  output vvl_div_rsp_t rsp_o
);

  logic               busy_q;
  logic [STEP_W-1:0]  cnt_q;
  logic [RATIO_W-1:0] rem_q;
  logic [RATIO_W-1:0] quo_q;
  logic [RATIO_W-1:0] div_q;

  logic [RATIO_W:0]   trial;
  logic [RATIO_W:0]   diff;
  logic               ge;
  logic [RATIO_W-1:0] rem_d;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[RATIO_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
  end

  // step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[RATIO_W-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

  `VVL_ASSERT_IMP(a_no_start_while_busy, req_i.start, !busy_q, "divider started while busy")
  `VVL_ASSERT_IMP(a_busy_has_steps, busy_q, cnt_q != '0, "divider busy with no steps left")
  `VVL_ASSERT_NXT(a_start_sets_busy, req_i.start, busy_q, "divider did not go busy after start")

endmodule

// ===== rtl/velocity_vector_limiter.sv =====
// Each axis transfer starts the bit-serial divider for its ratio, and no new axis is
// accepted until that divide is done.
// After the final axis the vector drains one axis at a time: each axis is read, runs the
// 16-step scaling divide when scaling applies, and waits in output while the output stalls.
// Reset loads the default registers, sets the largest ratio to 1.0 and the count to zero;
// the velocity store is not cleared.
// ----------------------------------------------------------------------------
// velocity_vector_limiter
// scales a commanded velocity vector so that no axis exceeds its limit
// ----------------------------------------------------------------------------
`include "velocity_vector_limiter_defines.svh"

module velocity_vector_limiter import vvl_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  vvl_in_if.sink                vel_i,
  vvl_out_if.source             vel_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = MAX_JOINTS + 3;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [AXIS_W-1:0] MAXJ_C = AXIS_W'(MAX_JOINTS);
  localparam logic [AXIS_W-1:0] LAST_POS = AXIS_W'(DEPTH - 1);

  // configuration registers
  logic [3:0]  joint_count_q;
  logic        base_active_q;
  logic [63:0] limits_low_q;
  logic [63:0] limits_high_q;
  logic [31:0] base_limits_q;

  // control state
  vvl_state_e         state_q, state_d;
  logic [AXIS_W-1:0]  count_q;
  logic [RATIO_W-1:0] largest_q;
  logic               scale_q;
  logic [AXIS_W-1:0]  k_q;
  logic               out_valid_q;

  // payload
  logic [VEL_W-1:0]   store_q [DEPTH];
  logic               lim_nz_q;
  logic [VEL_W-1:0]   res_q;
  logic [AXIS_W-1:0]  out_axis_q;
  logic [VEL_W-1:0]   out_vel_q;
  logic               out_scaled_q;
  logic               out_last_q;

  logic               cfg_we;
  logic [2:0]         reg_idx;
  logic [AXIS_W-1:0]  eff_joints;
  logic [AXIS_W-1:0]  vec_len;
  logic [AXIS_W-1:0]  pos;
  logic [AXIS_W-1:0]  base_off;
  logic [63:0]        lim_word;
  logic [LIMIT_W-1:0] lim;
  logic [VEL_W-1:0]   elem;
  logic [VEL_W-1:0]   q16;
  logic [RATIO_W-1:0] ratio_new;

  logic in_fire, div_done, out_free, last_elem, len_reached, draining;
  logic ratio_upd, emit_start, elem_rd, scale_done, out_load, vec_done;

  vvl_div_req_t div_req;
  vvl_div_rsp_t div_rsp;

  // register write and read decode
  assign reg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= JOINT_COUNT_RST;
      base_active_q <= 1'b0;
      limits_low_q  <= JOINT_LIM_RST;
      limits_high_q <= JOINT_LIM_RST;
      base_limits_q <= BASE_LIM_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_JOINT_COUNT: joint_count_q <= pwdata[3:0];
        REG_BASE_ACTIVE: base_active_q <= pwdata[0];
        REG_LIMITS_LOW:  limits_low_q  <= pwdata;
        REG_LIMITS_HIGH: limits_high_q <= pwdata;
        REG_BASE_LIMITS: base_limits_q <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_JOINT_COUNT: prdata = {60'd0, joint_count_q};
      REG_BASE_ACTIVE: prdata = {63'd0, base_active_q};
      REG_LIMITS_LOW:  prdata = limits_low_q;
      REG_LIMITS_HIGH: prdata = limits_high_q;
      REG_BASE_LIMITS: prdata = {32'd0, base_limits_q};
      default:         prdata = '0;
    endcase
  end

  // effective joint count and vector length
  always_comb begin
    if (joint_count_q == 4'd0) begin
      eff_joints = 4'd1;
    end else if (joint_count_q > MAXJ_C) begin
      eff_joints = MAXJ_C;
    end else begin
      eff_joints = joint_count_q;
    end
    vec_len = eff_joints + (base_active_q ? 4'd3 : 4'd0);
  end

  // store position and limit of the arriving axis
  always_comb begin
    pos      = (count_q > LAST_POS) ? LAST_POS : count_q;
    base_off = pos - eff_joints;
    lim_word = pos[2] ? limits_high_q : limits_low_q;
    if (pos < eff_joints) begin
      case (pos[1:0])
        2'd0:    lim = lim_word[15:0];
        2'd1:    lim = lim_word[31:16];
        2'd2:    lim = lim_word[47:32];
        default: lim = lim_word[63:48];
      endcase
    end else if (base_off < 4'd2) begin
      lim = base_limits_q[15:0];
    end else begin
      lim = base_limits_q[31:16];
    end
  end

  // handshake and status terms
  assign in_fire     = vel_i.valid && vel_i.ready;
  assign div_done    = !div_rsp.busy;
  assign out_free    = !out_valid_q || vel_o.ready;
  assign last_elem   = ((k_q + 4'd1) == vec_len);
  assign len_reached = (count_q >= vec_len);
  assign draining    = (state_q == ST_EMIT) || (state_q == ST_SCALE) || (state_q == ST_OUT);
  assign elem        = store_q[k_q[IDX_W-1:0]];
  assign q16         = div_rsp.quotient[VEL_W-1:0];
  assign ratio_new   = (lim_nz_q && (div_rsp.quotient > largest_q)) ?
                       div_rsp.quotient : largest_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_RATIO;
      ST_RATIO: if (div_done) state_d = len_reached ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_d = scale_q ? ST_SCALE : ST_OUT;
      ST_SCALE: if (div_done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = last_elem ? ST_IDLE : ST_EMIT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    vel_i.ready = (state_q == ST_IDLE);
    ratio_upd   = (state_q == ST_RATIO) && div_done;
    emit_start  = ratio_upd && len_reached;
    elem_rd     = (state_q == ST_EMIT);
    scale_done  = (state_q == ST_SCALE) && div_done;
    out_load    = (state_q == ST_OUT) && out_free;
    vec_done    = out_load && last_elem;

    if (state_q == ST_IDLE) begin
      // ready is high in idle, so a valid input is a transfer
      div_req.start    = vel_i.valid;
      div_req.rem_init = '0;
      div_req.dividend = {mag16(vel_i.velocity), 16'd0};
      div_req.divisor  = {16'd0, lim};
      div_req.steps    = RATIO_STEPS;
    end else begin
      div_req.start    = elem_rd && scale_q;
      div_req.rem_init = {16'd0, mag16(elem)};
      div_req.dividend = '0;
      div_req.divisor  = largest_q;
      div_req.steps    = SCALE_STEPS;
    end
  end

  vvl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      largest_q   <= ONE_Q16;
      scale_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        count_q <= pos + 4'd1;
      end else if (emit_start) begin
        count_q <= '0;
      end
      if (ratio_upd) begin
        largest_q <= ratio_new;
      end else if (vec_done) begin
        largest_q <= ONE_Q16;
      end
      if (emit_start) begin
        scale_q <= (ratio_new > ONE_Q16);
        k_q     <= '0;
      end else if (out_load && !last_elem) begin
        k_q <= k_q + 4'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (vel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // velocity store, element result and output register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_q[pos[IDX_W-1:0]] <= vel_i.velocity;
      lim_nz_q                <= (lim != '0);
    end
    if (elem_rd) begin
      res_q <= elem;
    end else if (scale_done) begin
      res_q <= res_q[VEL_W-1] ? ((~q16) + 16'd1) : q16;
    end
    if (out_load) begin
      out_axis_q   <= k_q;
      out_vel_q    <= res_q;
      out_scaled_q <= scale_q;
      out_last_q   <= last_elem;
    end
  end

  assign vel_o.valid           = out_valid_q;
  assign vel_o.axis            = out_axis_q;
  assign vel_o.scaled_velocity = $signed(out_vel_q);
  assign vel_o.was_scaled      = out_scaled_q;
  assign vel_o.last            = out_last_q;

  `VVL_ASSERT_NXT(a_accept_to_ratio, in_fire, state_q == ST_RATIO, "accept did not start ratio")
  `VVL_ASSERT_IMP(a_ratio_floor, 1'b1, largest_q >= ONE_Q16, "largest ratio below 1.0")
  `VVL_ASSERT_IMP(a_emit_count_clear, draining, count_q == '0, "count not cleared in drain")
  `VVL_ASSERT_IMP(a_axis_in_range, out_load, k_q < vec_len, "drained axis beyond vector length")

endmodule

// ===== tb/sv/velocity_vector_limiter_test.sv =====
// ----------------------------------------------------------------------------
// velocity_vector_limiter_test
// self-checking bench for the velocity vector limiter: axis velocities are
// streamed in over the input channel while the limits and the vector layout
// are changed through the register port; a local model of the common scaling
// predicts every emitted axis, and the output channel is compared against it
// ----------------------------------------------------------------------------
module velocity_vector_limiter_test;
  import vvl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STORE_DEPTH   = 11;
  localparam int          RANDOM_ITEMS  = 450;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          MAX_REPORTS   = 10;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  // one emitted axis
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic [VEL_W-1:0]  velocity;
    logic              scaled;
    logic              last;
  } axis_result_t;

  // directed stimulus rows
  typedef enum logic {ROW_WRITE, ROW_AXIS} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [2:0]       reg_idx;
    logic [63:0]      value;
    bit               typed;
    logic [VEL_W-1:0] want_velocity;
    bit               want_scaled;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  vvl_in_if  in_ch ();
  vvl_out_if out_ch ();

  velocity_vector_limiter #(
    .MAX_JOINTS(8)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vel_i  (in_ch),
    .vel_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // model copy of the registers
  logic [3:0]  lim_joint_count;
  logic        lim_base_active;
  logic [63:0] lim_joints_low;
  logic [63:0] lim_joints_high;
  logic [31:0] lim_base;

  // model copy of the vector state
  logic [VEL_W-1:0]   held_velocity [STORE_DEPTH];
  logic [RATIO_W-1:0] peak_ratio;
  int unsigned        held_count;

  axis_result_t pending_axes [$];
  plan_row_t    plan [$];

  bit          steady;
  bit          port_open;
  int          mismatches   = 0;
  int          results_seen = 0;
  int          scaled_seen  = 0;
  int          axes_sent;
  int          phases;
  int unsigned cycles       = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d axes outstanding", cycles,
               pending_axes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned joints_in_use();
    int unsigned j;
    j = lim_joint_count;
    if (j == 0) j = 1;
    if (j > 8) j = 8;
    return j;
  endfunction

  function automatic int unsigned vector_length();
    return joints_in_use() + (lim_base_active ? 3 : 0);
  endfunction

  function automatic int unsigned axis_limit(input int unsigned slot);
    int unsigned j;
    logic [63:0] word;
    j = joints_in_use();
    if (slot < j) begin
      word = (slot < 4) ? lim_joints_low : lim_joints_high;
      return word[(slot % 4) * 16 +: 16];
    end
    if (slot - j < 2) return lim_base[15:0];
    return lim_base[31:16];
  endfunction

  function automatic int unsigned speed_of(input logic [VEL_W-1:0] v);
    int w;
    w = $signed(v);
    return (w < 0) ? -w : w;
  endfunction

  // take one axis in; on the closing axis queue the whole scaled vector
  function automatic void absorb_velocity(input logic [VEL_W-1:0] v);
    int unsigned     slot;
    int unsigned     len;
    int unsigned     lim;
    longint unsigned ratio;
    longint unsigned q;
    int              y;
    bit              do_scale;
    axis_result_t    r;
    slot = held_count;
    len  = vector_length();
    if (slot > STORE_DEPTH - 1) slot = STORE_DEPTH - 1;
    held_velocity[slot] = v;
    lim = axis_limit(slot);
    // a zero limit leaves the axis unlimited
    if (lim != 0) begin
      ratio = 64'(speed_of(v)) << 16;
      ratio = ratio / lim;
      if (ratio > peak_ratio) peak_ratio = 32'(ratio);
    end
    held_count = slot + 1;
    if (held_count < len) return;
    do_scale = peak_ratio > ONE_Q16;
    for (int unsigned k = 0; k < len; k++) begin
      y = $signed(held_velocity[k]);
      if (do_scale) begin
        q = (64'(speed_of(held_velocity[k])) << 16) / peak_ratio;
        y = held_velocity[k][VEL_W-1] ? -int'(q) : int'(q);
      end
      r.axis     = AXIS_W'(k);
      r.velocity = VEL_W'(y);
      r.scaled   = do_scale;
      r.last     = (k + 1 == len);
      pending_axes.push_back(r);
    end
    peak_ratio = ONE_Q16;
    held_count = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random backpressure and checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= steady || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    axis_result_t got;
    axis_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.axis     = out_ch.axis;
      got.velocity = out_ch.scaled_velocity;
      got.scaled   = out_ch.was_scaled;
      got.last     = out_ch.last;
      results_seen++;
      if (got.scaled) scaled_seen++;
      if (pending_axes.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer axis %0d velocity %h", got.axis,
                                got.velocity));
      end else begin
        want = pending_axes.pop_front();
        if (got !== want)
          flag_mismatch($sformatf(
            "result %0d axis %0d/%0d velocity %h/%h scaled %b/%b last %b/%b (exp/act)",
            results_seen, want.axis, got.axis, want.velocity, got.velocity,
            want.scaled, got.scaled, want.last, got.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side and register port
  // ---------------------------------------------------------------------------

  // drop valid, let all expected axes drain, then give the divider time to finish
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_axes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    if (!port_open) settle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    port_open = 1'b1;
    case (idx)
      REG_JOINT_COUNT: lim_joint_count = value[3:0];
      REG_BASE_ACTIVE: lim_base_active = value[0];
      REG_LIMITS_LOW:  lim_joints_low  = value;
      REG_LIMITS_HIGH: lim_joints_high = value;
      REG_BASE_LIMITS: lim_base        = value[31:0];
      default: ;
    endcase
  endtask

  // one axis transfer, with an optional gap of random length in front
  task automatic push_velocity(input logic [VEL_W-1:0] v);
    int gap;
    if (port_open) begin
      @(negedge clk_i);
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      port_open = 1'b0;
    end
    gap = (!steady && $urandom_range(99) < 22) ? $urandom_range(1, 45) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid    <= 1'b0;
      in_ch.velocity <= VEL_W'($urandom);
    end
    @(negedge clk_i);
    in_ch.valid    <= 1'b1;
    in_ch.velocity <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    axes_sent++;
    absorb_velocity(v);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_write(input logic [2:0] idx, input logic [63:0] value);
    plan_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.value   = value;
    row.typed   = 1'b0;
    plan.push_back(row);
  endfunction

  function automatic void add_axis(input logic [VEL_W-1:0] v);
    plan_row_t row;
    row.kind  = ROW_AXIS;
    row.value = 64'(v);
    row.typed = 1'b0;
    plan.push_back(row);
  endfunction

  // single-axis vector whose outcome is known by hand
  function automatic void add_typed(input logic [VEL_W-1:0] v, input logic [VEL_W-1:0] want,
                                    input bit scaled);
    plan_row_t row;
    row.kind          = ROW_AXIS;
    row.value         = 64'(v);
    row.typed         = 1'b1;
    row.want_velocity = want;
    row.want_scaled   = scaled;
    plan.push_back(row);
  endfunction

  function automatic logic [15:0] draw_limit();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return 16'h0000;
    if (pick < 30) return 16'hFFFF;
    if (pick < 50) return 16'h1000;
    if (pick < 60) return 16'(1 << $urandom_range(15));
    return 16'($urandom);
  endfunction

  function automatic logic [63:0] draw_limit_word();
    return {draw_limit(), draw_limit(), draw_limit(), draw_limit()};
  endfunction

  function automatic logic [VEL_W-1:0] draw_velocity(input int mode);
    logic [VEL_W-1:0] corners [7];
    int               w;
    corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h1000, 16'hF000};
    if (mode == 0) begin
      w = $urandom_range(0, 1024);
      if ($urandom_range(1)) w = -w;
      return VEL_W'(w);
    end
    if (mode == 2) return corners[$urandom_range(6)];
    return VEL_W'($urandom);
  endfunction

  // new register setting for a random phase; the first three hit the extremes
  task automatic new_setting(input int phase);
    logic [3:0] joints;
    logic       base;
    if (phase == 0) begin
      joints = 4'd8;
      base   = 1'b1;
    end else if (phase == 1) begin
      joints = 4'd1;
      base   = 1'b0;
    end else if (phase == 2) begin
      joints = 4'd15;
      base   = 1'b1;
    end else begin
      joints = ($urandom_range(99) < 80) ? 4'($urandom_range(1, 8)) : 4'($urandom);
      base   = $urandom_range(1);
    end
    write_reg(REG_JOINT_COUNT, 64'(joints));
    write_reg(REG_BASE_ACTIVE, 64'(base));
    write_reg(REG_LIMITS_LOW, draw_limit_word());
    write_reg(REG_LIMITS_HIGH, draw_limit_word());
    write_reg(REG_BASE_LIMITS, {32'd0, draw_limit(), draw_limit()});
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int random_sent;
    int mode;
    int count;
    int vectors;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.velocity  = '0;
    steady          = 1'b0;
    port_open       = 1'b0;
    axes_sent       = 0;
    phases          = 0;
    random_sent     = 0;
    lim_joint_count = JOINT_COUNT_RST;
    lim_base_active = 1'b0;
    lim_joints_low  = JOINT_LIM_RST;
    lim_joints_high = JOINT_LIM_RST;
    lim_base        = BASE_LIM_RST;
    peak_ratio      = ONE_Q16;
    held_count      = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single joint against the reset limit of 1.0
    add_write(REG_JOINT_COUNT, 64'd1);
    add_typed(16'h2000, 16'h1000, 1'b1);
    add_typed(16'h8000, 16'hF000, 1'b1);
    add_typed(16'h7FFF, 16'h1000, 1'b1);
    add_typed(16'h1000, 16'h1000, 1'b0);
    add_typed(16'h0800, 16'h0800, 1'b0);
    // zero limit: the axis is unlimited
    add_write(REG_LIMITS_LOW, 64'd0);
    add_typed(16'h7FFF, 16'h7FFF, 1'b0);
    add_typed(16'h8000, 16'h8000, 1'b0);
    // joint count zero acts as one, smallest nonzero limit
    add_write(REG_JOINT_COUNT, 64'd0);
    add_write(REG_LIMITS_LOW, 64'd1);
    add_typed(16'h0001, 16'h0001, 1'b0);
    add_typed(16'hFFFF, 16'hFFFF, 1'b0);
    add_typed(16'h0002, 16'h0001, 1'b1);
    add_typed(16'h8000, 16'hFFFF, 1'b1);
    // joint count above range acts as eight, base on: full eleven axes
    add_write(REG_JOINT_COUNT, 64'd15);
    add_write(REG_BASE_ACTIVE, 64'd1);
    add_write(REG_LIMITS_LOW, 64'h0000_FFFF_2000_0800);
    add_write(REG_LIMITS_HIGH, 64'h1000_7FFF_0001_3000);
    add_write(REG_BASE_LIMITS, 64'hFFFF_0000);
    add_axis(16'h1000);
    add_axis(16'hC000);
    add_axis(16'h7FFF);
    add_axis(16'h8000);
    add_axis(16'h3000);
    add_axis(16'h0001);
    add_axis(16'h2000);
    add_axis(16'hF000);
    add_axis(16'h7FFF);
    add_axis(16'h8000);
    add_axis(16'h0FFF);
    // vector shortened below the stored count: the next axis closes it
    add_write(REG_JOINT_COUNT, 64'd4);
    add_write(REG_BASE_ACTIVE, 64'd0);
    add_axis(16'h0400);
    add_axis(16'hFC00);
    add_write(REG_JOINT_COUNT, 64'd1);
    add_axis(16'h0200);

    // walk the directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        push_velocity(plan[i].value[VEL_W-1:0]);
        if (plan[i].typed) begin
          pending_axes[pending_axes.size() - 1].velocity = plan[i].want_velocity;
          pending_axes[pending_axes.size() - 1].scaled   = plan[i].want_scaled;
        end
      end
    end

    // random phases: each starts from a drained block with a new setting
    while (random_sent < RANDOM_ITEMS) begin
      steady = (phases == 4 || phases == 5);
      new_setting(phases);
      vectors = $urandom_range(3, 10);
      for (int v = 0; v < vectors && random_sent < RANDOM_ITEMS; v++) begin
        mode  = $urandom_range(99);
        mode  = (mode < 25) ? 0 : (mode < 85) ? 1 : 2;
        // a vector already at or past a shortened length closes on its next axis
        if (held_count >= vector_length()) begin
          count = 1;
        end else begin
          count = int'(vector_length() - held_count);
        end
        // now and then a broken vector that stops short
        if ($urandom_range(99) < 8) count = $urandom_range(0, count);
        repeat (count) begin
          push_velocity(draw_velocity(mode));
          random_sent++;
        end
      end
      phases++;
    end
    steady = 1'b0;

    settle();

    $display("streamed %0d axis transfers: %0d directed rows, %0d random phases",
             axes_sent, plan.size(), phases);
    $display("checked %0d output transfers, %0d of them scaled, %0d mismatches",
             results_seen, scaled_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
